// ===== rtl/max_heap_priority_queue_defines.svh =====
// ----------------------------------------------------------------------------
// max_heap_priority_queue_defines
// assertion macros used by the priority queue datapath
// ----------------------------------------------------------------------------
`ifndef MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH
`define MAX_HEAP_PRIORITY_QUEUE_DEFINES_SVH

`ifndef SYNTHESIS
`define MHPQ_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("mhpq assertion failed");
`define MHPQ_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("mhpq assertion failed");
`else
`define MHPQ_ASSERT(label, prop)
`define MHPQ_ASSERT_ALWAYS(label, prop)
`endif

`endif

// ===== rtl/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhpq_pkg
// types and constants for the max-heap priority queue
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int HEAP_DEPTH = 256;
  localparam int IDX_W      = $clog2(HEAP_DEPTH);
  localparam int CNT_W      = $clog2(HEAP_DEPTH + 1);
  localparam int KEY_W      = 16;
  localparam int TAG_W      = 16;
  localparam int LIMIT_W    = 9;

  localparam logic ACT_INSERT  = 1'b0;
  localparam logic ACT_EXTRACT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } entry_t;

  typedef enum logic [2:0] {
    RD_NONE   = 3'd0,
    RD_ZERO   = 3'd1,
    RD_LAST   = 3'd2,
    RD_PARENT = 3'd3,
    RD_LEFT   = 3'd4,
    RD_RIGHT  = 3'd5
  } rd_sel_t;

  typedef enum logic [1:0] {
    WR_NONE  = 2'd0,
    WR_CUR   = 2'd1,
    WR_RDATA = 2'd2,
    WR_CHILD = 2'd3
  } wr_sel_t;

  typedef struct packed {
    logic    ld_insert;
    logic    ld_extract;
    logic    cap_root;
    logic    cap_last;
    logic    cap_left;
    rd_sel_t rd_sel;
    wr_sel_t wr_sel;
    logic    finish;
    status_t fin_status;
  } dp_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic idx_zero;
    logic parent_ge;
    logic no_left;
    logic child_gt;
  } dp_status_t;

endpackage

// ===== rtl/mhpq_ram.sv =====
// ----------------------------------------------------------------------------
// mhpq_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mhpq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/mhpq_dp.sv =====
// ----------------------------------------------------------------------------
// mhpq_dp
// heap datapath: entry store, count, limit, sift registers and result
// ----------------------------------------------------------------------------
`include "max_heap_priority_queue_defines.svh"

module mhpq_dp import mhpq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic [KEY_W-1:0]   entry_key,
  input  logic [TAG_W-1:0]   entry_tag,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  input  dp_cmd_t            cmd,
  output dp_status_t         st,
  output logic               done,
  output status_t            res_status,
  output logic [KEY_W-1:0]   res_key,
  output logic [TAG_W-1:0]   res_tag,
  output logic [CNT_W-1:0]   res_count
);

  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(HEAP_DEPTH);

  logic [CNT_W-1:0]   cnt;
  logic [LIMIT_W-1:0] limit;
  logic [IDX_W-1:0]   idx;
  entry_t             cur;
  entry_t             lv;
  entry_t             ext;
  logic               op_ext;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  entry_t             wdata;
  logic               re;
  logic [IDX_W-1:0]   raddr;
  entry_t             rdata;

  logic [IDX_W-1:0]   parent;
  logic [IDX_W:0]     left;
  logic [IDX_W+1:0]   right;
  logic               has_r;
  logic               best_is_l;
  logic [KEY_W-1:0]   best_key;
  logic               take_r;
  logic [IDX_W-1:0]   child;

  mhpq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (HEAP_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // heap index arithmetic
  assign parent    = (idx - 1'b1) >> 1;
  assign left      = {idx, 1'b1};
  assign right     = {1'b0, left} + 1'b1;
  assign has_r     = right < {1'b0, cnt};
  assign best_is_l = lv.key > cur.key;
  assign best_key  = best_is_l ? lv.key : cur.key;
  assign take_r    = has_r && (rdata.key > best_key);
  assign child     = take_r ? right[IDX_W-1:0] : left[IDX_W-1:0];

  assign st.full      = (cnt >= CNT_W'(limit)) || (cnt >= CNT_MAX);
  assign st.empty     = cnt == '0;
  assign st.idx_zero  = idx == '0;
  assign st.parent_ge = rdata.key >= cur.key;
  assign st.no_left   = left >= cnt;
  assign st.child_gt  = best_is_l || take_r;

  always_comb begin
    raddr = '0;
    unique case (cmd.rd_sel)
      RD_NONE:   raddr = '0;
      RD_ZERO:   raddr = '0;
      RD_LAST:   raddr = cnt[IDX_W-1:0];
      RD_PARENT: raddr = parent;
      RD_LEFT:   raddr = left[IDX_W-1:0];
      RD_RIGHT:  raddr = right[IDX_W-1:0];
      default:   raddr = '0;
    endcase
  end
  assign re = cmd.rd_sel != RD_NONE;

  always_comb begin
    wdata = cur;
    unique case (cmd.wr_sel)
      WR_NONE:  wdata = cur;
      WR_CUR:   wdata = cur;
      WR_RDATA: wdata = rdata;
      WR_CHILD: wdata = take_r ? rdata : lv;
      default:  wdata = cur;
    endcase
  end
  assign we    = cmd.wr_sel != WR_NONE;
  assign waddr = idx;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt   <= '0;
      limit <= LIMIT_W'(HEAP_DEPTH);
      done  <= 1'b0;
    end else begin
      if (cfg_we) begin
        limit <= cfg_wdata;
      end
      if (cmd.ld_insert) begin
        cnt <= cnt + 1'b1;
      end else if (cmd.ld_extract) begin
        cnt <= cnt - 1'b1;
      end
      done <= cmd.finish;
    end
  end

  // sift and result registers
  always_ff @(posedge clk) begin
    if (cmd.ld_insert) begin
      cur    <= '{key: entry_key, tag: entry_tag};
      idx    <= cnt[IDX_W-1:0];
      op_ext <= 1'b0;
    end
    if (cmd.ld_extract) begin
      op_ext <= 1'b1;
    end
    if (cmd.cap_root) begin
      ext <= rdata;
    end
    if (cmd.cap_last) begin
      cur <= rdata;
      idx <= '0;
    end
    if (cmd.cap_left) begin
      lv <= rdata;
    end
    if (cmd.wr_sel == WR_RDATA) begin
      idx <= parent;
    end else if (cmd.wr_sel == WR_CHILD) begin
      idx <= child;
    end
    if (cmd.finish) begin
      res_status <= cmd.fin_status;
      res_count  <= cnt;
      if (cmd.fin_status == ST_OK && op_ext) begin
        res_key <= ext.key;
        res_tag <= ext.tag;
      end else begin
        res_key <= '0;
        res_tag <= '0;
      end
    end
  end

  `MHPQ_ASSERT(a_cnt_bound, cnt <= CNT_MAX)
  `MHPQ_ASSERT(a_reject_zero, done && res_status != ST_OK |-> res_key == '0 && res_tag == '0)
  `MHPQ_ASSERT(a_full_count, done && res_status == ST_FULL |-> res_count >= limit || res_count == CNT_MAX)
  `MHPQ_ASSERT(a_empty_count, done && res_status == ST_EMPTY |-> res_count == '0)

endmodule

// ===== rtl/mhpq_ctrl.sv =====
// ----------------------------------------------------------------------------
// mhpq_ctrl
// controller sequencing insert sift up and extract sift down
// ----------------------------------------------------------------------------
module mhpq_ctrl import mhpq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic       action,
  input  dp_status_t st,
  output logic       busy,
  output dp_cmd_t    cmd
);

  typedef enum logic [7:0] {
    S_IDLE    = 8'b0000_0001,
    S_UP_CHK  = 8'b0000_0010,
    S_UP_CMP  = 8'b0000_0100,
    S_EX_ROOT = 8'b0000_1000,
    S_EX_LAST = 8'b0001_0000,
    S_DN_CHK  = 8'b0010_0000,
    S_DN_L    = 8'b0100_0000,
    S_DN_R    = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = state != S_IDLE;

  always_comb begin
    state_next     = state;
    cmd            = '0;
    cmd.rd_sel     = RD_NONE;
    cmd.wr_sel     = WR_NONE;
    cmd.fin_status = ST_OK;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          if (action == ACT_INSERT) begin
            if (st.full) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_FULL;
            end else begin
              cmd.ld_insert = 1'b1;
              state_next    = S_UP_CHK;
            end
          end else begin
            if (st.empty) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_EMPTY;
            end else begin
              cmd.ld_extract = 1'b1;
              cmd.rd_sel     = RD_ZERO;
              state_next     = S_EX_ROOT;
            end
          end
        end
      end
      S_UP_CHK: begin
        if (st.idx_zero) begin
          cmd.wr_sel = WR_CUR;
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.rd_sel = RD_PARENT;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (st.parent_ge) begin
          cmd.wr_sel = WR_CUR;
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.wr_sel = WR_RDATA;
          state_next = S_UP_CHK;
        end
      end
      S_EX_ROOT: begin
        cmd.cap_root = 1'b1;
        cmd.rd_sel   = RD_LAST;
        state_next   = S_EX_LAST;
      end
      S_EX_LAST: begin
        cmd.cap_last = 1'b1;
        state_next   = S_DN_CHK;
      end
      S_DN_CHK: begin
        if (st.no_left) begin
          cmd.wr_sel = WR_CUR;
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.rd_sel = RD_LEFT;
          state_next = S_DN_L;
        end
      end
      S_DN_L: begin
        cmd.cap_left = 1'b1;
        cmd.rd_sel   = RD_RIGHT;
        state_next   = S_DN_R;
      end
      S_DN_R: begin
        if (st.child_gt) begin
          cmd.wr_sel = WR_CHILD;
          state_next = S_DN_CHK;
        end else begin
          cmd.wr_sel = WR_CUR;
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/max_heap_priority_queue.sv =====
// insert: sift up steps one level per pass through the check and compare states
// extract: root and last entry read, then sift down steps one level per pass through check, left and right
// refused insert or extract on empty heap: done in the cycle after start
// one transfer at a time, next start taken in the cycle done is high; results cannot be held off
// synchronous reset empties the heap and sets the capacity limit to 256
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// binary max-heap priority queue over a one-write one-read entry ram
// ----------------------------------------------------------------------------
module max_heap_priority_queue import mhpq_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               action,
  input  logic [KEY_W-1:0]   entry_key,
  input  logic [TAG_W-1:0]   entry_tag,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata,
  output logic               done,
  output logic [1:0]         status,
  output logic [KEY_W-1:0]   out_key,
  output logic [TAG_W-1:0]   out_tag,
  output logic [CNT_W-1:0]   entry_count
);

  dp_cmd_t    cmd;
  dp_status_t st;
  status_t    res_status;

  mhpq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .st     (st),
    .busy   (busy),
    .cmd    (cmd)
  );

  mhpq_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .entry_key  (entry_key),
    .entry_tag  (entry_tag),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .cmd        (cmd),
    .st         (st),
    .done       (done),
    .res_status (res_status),
    .res_key    (out_key),
    .res_tag    (out_tag),
    .res_count  (entry_count)
  );

  assign status = res_status;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the max-heap priority queue: a queue of commands
// feeds a clocked driver, a clocked monitor checks every result strobe against
// a behavioural heap kept in the bench, capacity is changed between phases
// ----------------------------------------------------------------------------
module tb;
  import mhpq_pkg::*;

  localparam int STALL_LIMIT = 4000;

  typedef struct packed {
    logic             act;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } heap_cmd_t;

  typedef struct packed {
    status_t          st;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] count;
  } heap_result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               action = ACT_INSERT;
  logic [KEY_W-1:0]   entry_key = '0;
  logic [TAG_W-1:0]   entry_tag = '0;
  logic               cfg_we = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata = '0;
  logic               busy;
  logic               done;
  logic [1:0]         status;
  logic [KEY_W-1:0]   out_key;
  logic [TAG_W-1:0]   out_tag;
  logic [CNT_W-1:0]   entry_count;

  heap_cmd_t    ops_pending[$];
  heap_result_t results_due[$];
  heap_cmd_t    next_op;
  heap_result_t want;

  entry_t      heap_mem[HEAP_DEPTH];
  int unsigned heap_n = 0;
  int unsigned cap_reg = 256;

  int idle_pct = 0;
  int gap_left = 0;
  int stall_cycles = 0;
  int n_sent = 0;
  int n_results = 0;
  int n_mismatch = 0;
  int n_full = 0;
  int n_empty = 0;
  int peak_n = 0;

  max_heap_priority_queue uut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .action     (action),
    .entry_key  (entry_key),
    .entry_tag  (entry_tag),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .done       (done),
    .status     (status),
    .out_key    (out_key),
    .out_tag    (out_tag),
    .entry_count(entry_count)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // behavioural heap: applies one command and returns the result it causes
  function automatic heap_result_t apply_heap_op(logic act, logic [KEY_W-1:0] k,
                                                 logic [TAG_W-1:0] t);
    heap_result_t r;
    int unsigned  lim, i, p, l, rc, best;
    entry_t       tmp;
    bit           walking;
    r.st  = ST_OK;
    r.key = '0;
    r.tag = '0;
    lim = (cap_reg < HEAP_DEPTH) ? cap_reg : HEAP_DEPTH;
    if (act == ACT_INSERT) begin
      if (heap_n >= lim) begin
        r.st = ST_FULL;
        n_full++;
      end else begin
        heap_mem[heap_n] = '{key: k, tag: t};
        i = heap_n;
        heap_n++;
        walking = 1'b1;
        while (walking && i > 0) begin
          p = (i + 1) / 2 - 1;
          if (heap_mem[p].key >= heap_mem[i].key) begin
            walking = 1'b0;
          end else begin
            tmp = heap_mem[p];
            heap_mem[p] = heap_mem[i];
            heap_mem[i] = tmp;
            i = p;
          end
        end
      end
    end else begin
      if (heap_n == 0) begin
        r.st = ST_EMPTY;
        n_empty++;
      end else begin
        r.key = heap_mem[0].key;
        r.tag = heap_mem[0].tag;
        heap_n--;
        heap_mem[0] = heap_mem[heap_n];
        i = 0;
        walking = 1'b1;
        while (walking) begin
          l    = 2 * i + 1;
          rc   = 2 * i + 2;
          best = i;
          if (l < heap_n && heap_mem[l].key > heap_mem[best].key) best = l;
          if (rc < heap_n && heap_mem[rc].key > heap_mem[best].key) best = rc;
          if (best == i) begin
            walking = 1'b0;
          end else begin
            tmp = heap_mem[i];
            heap_mem[i] = heap_mem[best];
            heap_mem[best] = tmp;
            i = best;
          end
        end
      end
    end
    if (heap_n > peak_n) peak_n = heap_n;
    r.count = heap_n[CNT_W-1:0];
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else begin
      if (gap_left > 0) gap_left--;
      if (start && !busy) begin
        results_due.push_back(apply_heap_op(action, entry_key, entry_tag));
        n_sent++;
        if ($urandom_range(99) < idle_pct) gap_left = $urandom_range(1, 8);
      end
      if (!(start && busy)) begin
        if (gap_left == 0 && ops_pending.size() > 0) begin
          next_op = ops_pending.pop_front();
          action    <= next_op.act;
          entry_key <= next_op.key;
          entry_tag <= next_op.tag;
          start     <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst && done) begin
      n_results++;
      if (results_due.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= 10)
          $display("%0t: unexpected result, status %0d key %h tag %h count %0d",
                   $realtime, status, out_key, out_tag, entry_count);
      end else begin
        want = results_due.pop_front();
        if (status !== want.st || out_key !== want.key || out_tag !== want.tag ||
            entry_count !== want.count) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display({"%0t: result %0d mismatch (expected/actual): status %0d/%0d",
                      " key %h/%h tag %h/%h count %0d/%0d"},
                     $realtime, n_results, want.st, status, want.key, out_key,
                     want.tag, out_tag, want.count, entry_count);
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || cfg_we) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  task automatic queue_op(input logic act, input logic [KEY_W-1:0] k,
                          input logic [TAG_W-1:0] t);
    ops_pending.push_back('{act: act, key: k, tag: t});
  endtask

  task automatic wait_drained();
    while (ops_pending.size() != 0 || start || busy || results_due.size() != 0)
      @(posedge clk);
  endtask

  task automatic set_capacity(input logic [LIMIT_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    cap_reg = v;
  endtask

  function automatic logic [KEY_W-1:0] pick_key();
    case ($urandom_range(3))
      0: return KEY_W'($urandom_range(3));
      1: return $urandom_range(1) ? '1 : '0;
      default: return KEY_W'($urandom);
    endcase
  endfunction

  task automatic random_run(input logic [LIMIT_W-1:0] cap, input int n,
                            input int ins_pct, input int idle);
    set_capacity(cap);
    idle_pct = idle;
    repeat (n) begin
      if ($urandom_range(99) < ins_pct) queue_op(ACT_INSERT, pick_key(), TAG_W'($urandom));
      else queue_op(ACT_EXTRACT, KEY_W'($urandom), TAG_W'($urandom));
    end
    wait_drained();
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset capacity: empty extract, extremes, tied keys, drain past empty
    idle_pct = 30;
    queue_op(ACT_EXTRACT, '0, '0);
    queue_op(ACT_INSERT, 16'h0000, 16'h0000);
    queue_op(ACT_INSERT, 16'hFFFF, 16'hFFFF);
    queue_op(ACT_INSERT, 16'h8000, 16'h0001);
    queue_op(ACT_INSERT, 16'h8000, 16'h0002);
    queue_op(ACT_INSERT, 16'h8000, 16'h0003);
    queue_op(ACT_INSERT, 16'h5555, 16'hAAAA);
    queue_op(ACT_INSERT, 16'hAAAA, 16'h5555);
    repeat (8) queue_op(ACT_EXTRACT, '1, '1);
    wait_drained();

    // capacity of one: second insert refused
    set_capacity(9'd1);
    queue_op(ACT_INSERT, 16'h1234, 16'h4321);
    queue_op(ACT_INSERT, 16'hFFFF, 16'h0F0F);
    queue_op(ACT_EXTRACT, '0, '0);
    wait_drained();

    // zero capacity refuses every insert
    set_capacity(9'd0);
    queue_op(ACT_INSERT, 16'h7777, 16'h1111);
    wait_drained();

    // limit lowered below the count: inserts refused, extracts still work
    set_capacity(9'h1FF);
    queue_op(ACT_INSERT, 16'h0010, 16'h0001);
    queue_op(ACT_INSERT, 16'h0020, 16'h0002);
    queue_op(ACT_INSERT, 16'h0030, 16'h0003);
    queue_op(ACT_INSERT, 16'h0005, 16'h0004);
    wait_drained();
    set_capacity(9'd2);
    queue_op(ACT_INSERT, 16'h0040, 16'h0005);
    queue_op(ACT_EXTRACT, '0, '0);
    wait_drained();

    random_run(9'h1FF, 360, 90, 25);
    random_run(9'd200, 120, 50, 0);
    random_run(9'd256, 290, 20, 30);
    random_run(9'd7,   250, 55, 40);
    random_run(9'd1,   100, 50, 20);
    random_run(9'd64,  230, 62, 0);
    random_run(9'd256, 100, 50, 0);

    repeat (40) @(posedge clk);
    $display("run covered %0d commands and %0d results, peak occupancy %0d",
             n_sent, n_results, peak_n);
    $display("refused inserts %0d, extracts on empty %0d, mismatches %0d",
             n_full, n_empty, n_mismatch);
    if (n_mismatch == 0 && results_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/mhpq_pkg.sv
rtl/mhpq_ram.sv
rtl/mhpq_dp.sv
rtl/mhpq_ctrl.sv
rtl/max_heap_priority_queue.sv
tb/tb.sv
